// ===== src/lbm_pkg.sv =====
package lbm_pkg;

	// Fixed field widths
	localparam int unsigned COL_W     = 6;
	localparam int unsigned COL_SPAN  = 1 << COL_W;
	localparam int unsigned LVL_W     = 16;
	localparam int unsigned MS_W      = 16;
	localparam int unsigned GAIN_W    = 9;
	localparam int unsigned ROWS_W    = 6;
	localparam int unsigned BRIGHT_W  = 8;
	localparam int unsigned COLUMNS_DEF = 64;

	// Register map (index = paddr[3:2])
	localparam int unsigned PADDR_W = 4;
	localparam logic [1:0] REG_GAIN    = 2'd0;
	localparam logic [1:0] REG_HOLD_EN = 2'd1;
	localparam logic [1:0] REG_ROWS    = 2'd2;
	localparam logic [1:0] REG_HOLD_MS = 2'd3;

	localparam logic [GAIN_W-1:0] GAIN_RST    = 9'd230;
	localparam logic              HOLD_EN_RST = 1'b1;
	localparam logic [ROWS_W-1:0] ROWS_RST    = 6'd24;
	localparam logic [MS_W-1:0]   HOLD_MS_RST = 16'd500;

	// Q0.16 rates: 0.4 and 0.15
	localparam logic [14:0] ATTACK_Q16 = 15'd26214;
	localparam logic [14:0] DECAY_Q16  = 15'd9830;

	// floor(y/20) = (y * DIV20_M) >> DIV20_SH, exact for y < 2^18
	localparam logic [16:0] DIV20_M  = 17'd104858;
	localparam int unsigned DIV20_SH = 21;
	// floor(t/5) = (t * DIV5_M) >> DIV5_SH, exact for t < 2730
	localparam logic [10:0] DIV5_M   = 11'd1639;
	localparam int unsigned DIV5_SH  = 13;
	// floor(t/25) = (t * DIV25_M) >> DIV25_SH, exact for t < 43690
	localparam logic [13:0] DIV25_M  = 14'd10486;
	localparam int unsigned DIV25_SH = 18;

	localparam logic [10:0] BODY_BASE = 11'd512;
	localparam logic [12:0] TOP_BASE  = 13'd3072;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [LVL_W-1:0] target_level;
		logic [MS_W-1:0]  elapsed_ms;
	} item_t;

	typedef struct packed {
		logic [LVL_W-1:0]    level;
		logic [LVL_W-1:0]    peak_level;
		logic                peak_shown;
		logic [ROWS_W-1:0]   lit_count;
		logic [ROWS_W-1:0]   peak_row;
		logic                peak_row_valid;
		logic [BRIGHT_W-1:0] body_brightness;
		logic [BRIGHT_W-1:0] top_brightness;
	} result_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic              hold_en;
		logic [ROWS_W-1:0] rows;
		logic [MS_W-1:0]   hold_ms;
	} cfg_t;

	// One strobe per datapath step
	typedef struct packed {
		logic load;
		logic calc;
		logic step;
		logic upd;
		logic emit;
	} cmd_t;

	// col mod cols without a divider; only called with constant arguments
	function automatic int unsigned wrap_col(input int unsigned col, input int unsigned cols);
		int unsigned r;
		r = 0;
		for (int unsigned i = 0; i < col; i++) begin
			if (r + 1 == cols) begin
				r = 0;
			end else begin
				r = r + 1;
			end
		end
		return r;
	endfunction

endpackage

// ===== src/lbm_ram.sv =====
module lbm_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/lbm_ctrl.sv =====
module lbm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	output logic          result_valid,
	input  logic          result_ready,
	output lbm_pkg::cmd_t cmd
);
	import lbm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_PEAK = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_vld_q;
	logic       out_free;

	assign out_free   = !out_vld_q || result_ready;
	assign item_ready = (state_q == ST_IDLE);

	assign cmd.load = item_ready && item_valid;
	assign cmd.calc = (state_q == ST_READ);
	assign cmd.step = (state_q == ST_MUL);
	assign cmd.upd  = (state_q == ST_PEAK);
	assign cmd.emit = (state_q == ST_FIN) && out_free;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_nxt = ST_READ;
			end
			ST_READ: state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_PEAK;
			ST_PEAK: state_nxt = ST_FIN;
			ST_FIN: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_vld_q;

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.calc, cmd.step, cmd.upd, cmd.emit}))
		else $error("more than one datapath step active");

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.calc ##1 cmd.step ##1 cmd.upd)
		else $error("accepted transfer did not run through the datapath steps");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> result_valid)
		else $error("finished result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !cmd.emit)
		else $error("result overwritten while stalled");

endmodule

// ===== src/lbm_dp.sv =====
module lbm_dp #(
	parameter int unsigned COLUMNS = lbm_pkg::COLUMNS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lbm_pkg::cmd_t    cmd,
	input  lbm_pkg::item_t   item,
	input  lbm_pkg::cfg_t    cfg,
	output lbm_pkg::result_t result
);
	import lbm_pkg::*;

	localparam int unsigned IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int unsigned ENT_W = 2 * LVL_W + MS_W;

	// Column wrap table
	logic [IDX_W-1:0] wrap_tbl [COL_SPAN];
	for (genvar g = 0; g < COL_SPAN; g++) begin : g_wrap
		localparam int unsigned WRAPPED = wrap_col(g, COLUMNS);
		assign wrap_tbl[g] = IDX_W'(WRAPPED);
	end

	// Effective rates, refreshed every cycle from the gain register
	logic [23:0]      att_p, dec_p;
	logic [LVL_W-1:0] r_att_q, r_dec_q;
	assign att_p = 24'(ATTACK_Q16) * 24'(cfg.gain);
	assign dec_p = 24'(DECAY_Q16) * 24'(cfg.gain);

	always_ff @(posedge clk) begin
		r_att_q <= att_p[23:8];
		r_dec_q <= dec_p[23:8];
	end

	// Column store: {level, peak, timer}; entries not yet written read as zero
	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   col_q;
	logic [ENT_W-1:0]   rdata, wdata;
	logic [COLUMNS-1:0] vld_q;
	logic               vld_s1;

	assign rd_idx = wrap_tbl[item.column];

	lbm_ram #(.WIDTH(ENT_W), .DEPTH(COLUMNS)) u_store (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (col_q),
		.wdata (wdata),
		.re    (cmd.load),
		.raddr (rd_idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.upd) begin
			vld_q[col_q] <= 1'b1;
		end
	end

	// Load
	logic [LVL_W-1:0] tgt_q;
	logic [MS_W-1:0]  el_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q  <= rd_idx;
			tgt_q  <= item.target_level;
			el_q   <= item.elapsed_ms;
			vld_s1 <= vld_q[rd_idx];
		end
	end

	// Calc: pick stored state, distance to target
	logic [ENT_W-1:0] ent;
	logic [LVL_W-1:0] cur, diff;
	logic             up;
	logic [LVL_W-1:0] cur_q, pk_q, diff_q;
	logic [MS_W-1:0]  tm_q;
	logic             up_q;

	assign ent  = vld_s1 ? rdata : '0;
	assign cur  = ent[ENT_W-1 -: LVL_W];
	assign up   = cur < tgt_q;
	assign diff = up ? (tgt_q - cur) : (cur - tgt_q);

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			cur_q  <= cur;
			pk_q   <= ent[MS_W +: LVL_W];
			tm_q   <= ent[MS_W-1:0];
			up_q   <= up;
			diff_q <= diff;
		end
	end

	// Step: level moves toward target by diff * rate
	logic [2*LVL_W-1:0] step_p;
	logic [LVL_W-1:0]   lvl_q;

	assign step_p = (2*LVL_W)'(diff_q) * (2*LVL_W)'(up_q ? r_att_q : r_dec_q);

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			lvl_q <= up_q ? (cur_q + step_p[2*LVL_W-1 -: LVL_W])
			              : (cur_q - step_p[2*LVL_W-1 -: LVL_W]);
		end
	end

	// Update: peak hold, lit count, brightness numerators
	logic [LVL_W:0]     y20;
	logic [33:0]        q20_p;
	logic [LVL_W-1:0]   pk_dec, pk_n;
	logic [MS_W-1:0]    tm_n;
	logic [21:0]        lit_p;
	logic [ROWS_W-1:0]  lit0, lit;
	logic [21:0]        lvl20;
	logic [25:0]        b_p;
	logic [28:0]        t_p;
	logic [LVL_W-1:0]   pk2_q;
	logic [ROWS_W-1:0]  lit_q;
	logic               shown_q;
	logic [10:0]        bnum_q;
	logic [12:0]        tnum_q;

	// floor(19*pk/20) = pk - ceil(pk/20)
	assign y20    = (LVL_W+1)'(pk_q) + (LVL_W+1)'(19);
	assign q20_p  = 34'(y20) * 34'(DIV20_M);
	assign pk_dec = pk_q - LVL_W'(q20_p >> DIV20_SH);

	always_comb begin
		pk_n = pk_q;
		tm_n = tm_q;
		if (cfg.hold_en) begin
			if (lvl_q >= pk_q) begin
				pk_n = lvl_q;
				tm_n = cfg.hold_ms;
			end else if (tm_q != '0) begin
				tm_n = (tm_q > el_q) ? (tm_q - el_q) : '0;
			end else begin
				pk_n = pk_dec;
			end
		end
	end

	assign wdata = {lvl_q, pk_n, tm_n};

	assign lit_p = 22'(lvl_q) * 22'(cfg.rows);
	assign lit0  = lit_p[21:16];
	// 20*level against full scale: a level above the 0.05 floor lights one LED
	assign lvl20 = 22'({lvl_q, 4'b0}) + 22'({lvl_q, 2'b0});
	assign lit   = (lit0 == '0 && cfg.rows != '0 && lvl20 > 22'(1 << LVL_W))
	               ? ROWS_W'(1) : lit0;

	// 768*level and 4608*level by shift and add
	assign b_p = {lvl_q, 10'b0} - {2'b0, lvl_q, 8'b0};
	assign t_p = {lvl_q, 13'b0} - {1'b0, lvl_q, 12'b0} + {4'b0, lvl_q, 9'b0};

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			pk2_q   <= pk_n;
			lit_q   <= lit;
			shown_q <= cfg.hold_en && (tm_n != '0);
			bnum_q  <= BODY_BASE + 11'(b_p[25:16]);
			tnum_q  <= TOP_BASE + 13'(t_p[28:16]);
		end
	end

	// Emit: peak row and brightness
	logic [21:0]        prow_p;
	logic [ROWS_W-1:0]  prow_full;
	logic               pvalid;
	logic [21:0]        body_p;
	logic [26:0]        top_p;
	logic [8:0]         body_full, top_full;
	logic [BRIGHT_W-1:0] body_sat, top_sat;
	result_t            res_q;

	assign prow_p    = 22'(pk2_q) * 22'(cfg.rows);
	assign prow_full = prow_p[21:16];
	assign pvalid    = (prow_full != '0) && (prow_full <= cfg.rows);

	assign body_p    = 22'(bnum_q) * 22'(DIV5_M);
	assign top_p     = 27'(tnum_q) * 27'(DIV25_M);
	assign body_full = 9'(body_p >> DIV5_SH);
	assign top_full  = 9'(top_p >> DIV25_SH);
	assign body_sat  = body_full[8] ? '1 : body_full[7:0];
	assign top_sat   = top_full[8] ? '1 : top_full[7:0];

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.level           <= lvl_q;
			res_q.peak_level      <= pk2_q;
			res_q.peak_shown      <= shown_q;
			res_q.lit_count       <= lit_q;
			res_q.peak_row        <= pvalid ? (prow_full - ROWS_W'(1)) : '0;
			res_q.peak_row_valid  <= pvalid;
			res_q.body_brightness <= (lit_q == '0) ? '0 : body_sat;
			res_q.top_brightness  <= (lit_q == '0) ? '0 : top_sat;
		end
	end

	assign result = res_q;

endmodule

// ===== src/led_bar_meter_ballistics.sv =====
// Each item runs through the store read, smoothing multiply, peak update and
// output steps one after another on a single datapath; the next item is taken
// only once the previous one has left the output step.
// A new item is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) clears all column levels, peaks and timers
// at once through per-column valid bits and loads the register defaults.
module led_bar_meter_ballistics #(
	parameter int unsigned COLUMNS = lbm_pkg::COLUMNS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Item channel
	input  logic                          item_valid,
	output logic                          item_ready,
	input  lbm_pkg::item_t                item,
	// Result channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output lbm_pkg::result_t              result,
	// Register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lbm_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import lbm_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	logic wr_xfer;

	// Register port: zero wait states, write lands on the access cycle.
	assign pready  = 1'b1;
	assign wr_xfer = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain    <= GAIN_RST;
			cfg_q.hold_en <= HOLD_EN_RST;
			cfg_q.rows    <= ROWS_RST;
			cfg_q.hold_ms <= HOLD_MS_RST;
		end else if (wr_xfer) begin
			case (paddr[3:2])
				REG_GAIN:    cfg_q.gain    <= pwdata[GAIN_W-1:0];
				REG_HOLD_EN: cfg_q.hold_en <= pwdata[0];
				REG_ROWS:    cfg_q.rows    <= pwdata[ROWS_W-1:0];
				REG_HOLD_MS: cfg_q.hold_ms <= pwdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Readback, zero-extended
	always_comb begin
		case (paddr[3:2])
			REG_GAIN:    prdata = 32'(cfg_q.gain);
			REG_HOLD_EN: prdata = 32'(cfg_q.hold_en);
			REG_ROWS:    prdata = 32'(cfg_q.rows);
			REG_HOLD_MS: prdata = 32'(cfg_q.hold_ms);
			default:     prdata = '0;
		endcase
	end

	// Sequencer: at most one step strobe per cycle, owns both handshakes.
	lbm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd)
	);

	// Datapath: column store, smoothing, peak hold, LED mapping.
	lbm_dp #(.COLUMNS(COLUMNS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.cfg    (cfg_q),
		.result (result)
	);

endmodule

// ===== dv/led_bar_meter_ballistics_tb.sv =====
// Bench for the LED bar meter ballistics block.
// Column updates stream in over valid/ready. Each accepted transfer is run
// through a local model of the smoothing and peak-hold state and its result
// is queued. Every result transfer is then checked against the oldest
// queued result, field by field. Registers go through the APB-style port
// only when the block is drained.
module led_bar_meter_ballistics_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lbm_pkg::*;

	localparam int unsigned COLS        = 64;
	localparam longint unsigned LVL_ONE = 64'd65536;
	// Q0.16 smoothing rates, 0.4 up and 0.15 down
	localparam longint unsigned RATE_UP   = 64'd26214;
	localparam longint unsigned RATE_DOWN = 64'd9830;
	// generous: ~2k items, heavy stalls, long hold-off
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned PHASE_ITEMS   = 240;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned LONG_HOLDOFF  = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	led_bar_meter_ballistics u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Column state and register copy used to predict results
	logic [LVL_W-1:0]  col_level [COLS];
	logic [LVL_W-1:0]  col_peak  [COLS];
	logic [MS_W-1:0]   col_timer [COLS];
	logic [GAIN_W-1:0] cfg_gain    = GAIN_RST;
	logic              cfg_hold_en = HOLD_EN_RST;
	logic [ROWS_W-1:0] cfg_rows    = ROWS_RST;
	logic [MS_W-1:0]   cfg_hold_ms = HOLD_MS_RST;

	item_t   pending_items[$];
	result_t expected_results[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          item_busy = 1'b0;      // an item is on the bus awaiting its transfer
	int unsigned holdoff_request = 0;   // cycles of forced receiver stall
	bit          holdoff_active = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// Smoothing, then peak hold, then the display fields for one column update.
	// 64 columns and a 6-bit index, so the column wrap is a no-op.
	function automatic result_t predict_column_update(input item_t it);
		int unsigned     col;
		longint unsigned cur, tgt, el, rate, lvl, pk, tm, rows;
		longint unsigned lit, prow, num, body, top;
		bit              row_ok;
		result_t         r;
		col = 32'(it.column);
		cur = 64'(col_level[col]);
		tgt = 64'(it.target_level);
		el  = 64'(it.elapsed_ms);
		rate = (((cur < tgt) ? RATE_UP : RATE_DOWN) * 64'(cfg_gain)) >> 8;
		if (tgt > cur) begin
			lvl = cur + (((tgt - cur) * rate) >> 16);
		end else begin
			lvl = cur - (((cur - tgt) * rate) >> 16);
		end
		col_level[col] = lvl[LVL_W-1:0];

		pk = 64'(col_peak[col]);
		tm = 64'(col_timer[col]);
		if (cfg_hold_en) begin
			if (lvl >= pk) begin
				// new peak: capture and reload the hold time
				pk = lvl;
				tm = 64'(cfg_hold_ms);
			end else if (tm > 0) begin
				tm = (tm > el) ? tm - el : 0;
			end else begin
				pk = (pk * 19) / 20;
			end
			col_peak[col]  = pk[LVL_W-1:0];
			col_timer[col] = tm[MS_W-1:0];
		end

		rows = 64'(cfg_rows);
		lit = (lvl * rows) >> 16;
		// any level above the 0.05 floor lights at least one LED
		if (lit == 0 && rows > 0 && lvl * 20 > LVL_ONE) begin
			lit = 1;
		end
		prow = (pk * rows) >> 16;
		row_ok = (prow >= 1 && prow <= rows);
		prow = row_ok ? prow - 1 : 0;

		num  = 512 * LVL_ONE + 768 * lvl;
		body = num / (5 * LVL_ONE);
		top  = (6 * num) / (25 * LVL_ONE);
		if (body > 255) begin
			body = 255;
		end
		if (top > 255) begin
			top = 255;
		end
		if (lit == 0) begin
			body = 0;
			top  = 0;
		end

		r.level           = lvl[LVL_W-1:0];
		r.peak_level      = pk[LVL_W-1:0];
		r.peak_shown      = cfg_hold_en && (tm > 0);
		r.lit_count       = lit[ROWS_W-1:0];
		r.peak_row        = prow[ROWS_W-1:0];
		r.peak_row_valid  = row_ok;
		r.body_brightness = body[BRIGHT_W-1:0];
		r.top_brightness  = top[BRIGHT_W-1:0];
		return r;
	endfunction

	// Hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Sender: drives at the falling edge, one item per transfer, random gaps
	always @(negedge clk) begin
		if (arst_n && !item_busy) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				item       <= pending_items.pop_front();
				item_valid <= 1'b1;
				item_busy   = 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a forced hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			result_ready <= !holdoff_active && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Long hold-off, timed in cycles here so the stimulus keeps feeding items
	always begin
		wait (holdoff_request != 0);
		holdoff_active = 1'b1;
		repeat (holdoff_request) @(posedge clk);
		holdoff_active  = 1'b0;
		holdoff_request = 0;
	end

	// Transfers on both channels are sampled at the rising edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n && item_valid && item_ready) begin
			expected_results.push_back(predict_column_update(item));
			item_busy = 1'b0;
		end
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result transfer: %h", result);
				end
			end else begin
				want = expected_results.pop_front();
				if (result.level !== want.level ||
				    result.peak_level !== want.peak_level ||
				    result.peak_shown !== want.peak_shown ||
				    result.lit_count !== want.lit_count ||
				    result.peak_row !== want.peak_row ||
				    result.peak_row_valid !== want.peak_row_valid ||
				    result.body_brightness !== want.body_brightness ||
				    result.top_brightness !== want.top_brightness) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result mismatch: exp lvl=%0d pk=%0d shown=%0d lit=%0d",
						         want.level, want.peak_level, want.peak_shown,
						         want.lit_count, " row=%0d rowv=%0d body=%0d top=%0d",
						         want.peak_row, want.peak_row_valid,
						         want.body_brightness, want.top_brightness);
						$display("                 got lvl=%0d pk=%0d shown=%0d lit=%0d",
						         result.level, result.peak_level, result.peak_shown,
						         result.lit_count, " row=%0d rowv=%0d body=%0d top=%0d",
						         result.peak_row, result.peak_row_valid,
						         result.body_brightness, result.top_brightness);
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_GAIN:    cfg_gain    = val[GAIN_W-1:0];
			REG_HOLD_EN: cfg_hold_en = val[0];
			REG_ROWS:    cfg_rows    = val[ROWS_W-1:0];
			REG_HOLD_MS: cfg_hold_ms = val[MS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_meter(input int unsigned gain, input int unsigned hold_en,
	                         input int unsigned rows, input int unsigned hold_ms);
		write_reg(REG_GAIN, gain);
		write_reg(REG_HOLD_EN, hold_en);
		write_reg(REG_ROWS, rows);
		write_reg(REG_HOLD_MS, hold_ms);
	endtask

	task automatic queue_update(input int unsigned col, input int unsigned tgt,
	                            input int unsigned el);
		item_t it;
		it.column       = COL_W'(col);
		it.target_level = LVL_W'(tgt);
		it.elapsed_ms   = MS_W'(el);
		pending_items.push_back(it);
	endtask

	// Drained: nothing left to send, nothing on the bus, every result back
	task automatic wait_drained();
		while (pending_items.size() != 0 || item_busy || expected_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Mostly a handful of columns so each one sees attack, hold, countdown and
	// peak decay in turn; occasional spikes and silences, some full-range noise.
	function automatic item_t random_update();
		item_t       it;
		int unsigned pick;
		it.column = COL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
		                                               : $urandom_range(0, 3));
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			it.target_level = 16'hFFFF;
		end else if (pick == 1) begin
			it.target_level = '0;
		end else if (pick <= 3) begin
			it.target_level = LVL_W'($urandom_range(0, 65535));
		end else begin
			it.target_level = LVL_W'($urandom_range(0, 8000));
		end
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			it.elapsed_ms = '0;
		end else if (pick == 1) begin
			it.elapsed_ms = 16'hFFFF;
		end else if (pick == 2) begin
			it.elapsed_ms = MS_W'($urandom_range(0, 65535));
		end else begin
			it.elapsed_ms = MS_W'($urandom_range(0, 200));
		end
		return it;
	endfunction

	initial begin
		for (int i = 0; i < COLS; i++) begin
			col_level[i] = '0;
			col_peak[i]  = '0;
			col_timer[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset defaults: attack with capture, decay while the timer
		// counts down, timer saturating at zero, then the peak decaying.
		queue_update(0, 65535, 0);
		queue_update(0, 65535, 0);
		queue_update(0, 0, 100);
		queue_update(0, 0, 65535);
		queue_update(0, 0, 0);
		queue_update(0, 0, 0);
		queue_update(63, 65535, 65535);
		queue_update(63, 1000, 1);
		queue_update(1, 0, 0);
		queue_update(2, 30000, 7);
		wait_drained();

		// hold disabled, zero rows, full gain
		set_meter(511, 0, 0, 0);
		queue_update(0, 65535, 0);
		queue_update(63, 0, 65535);
		queue_update(5, 40000, 3);
		wait_drained();

		// zero gain freezes levels; longest hold, most rows
		set_meter(0, 1, 63, 65535);
		queue_update(0, 12345, 10);
		queue_update(3, 65535, 0);
		queue_update(3, 0, 1);
		wait_drained();

		// few rows: a level just above the floor still lights one LED;
		// zero hold time lets the peak decay on the next fall
		set_meter(256, 1, 10, 0);
		queue_update(4, 12000, 0);
		queue_update(4, 0, 0);
		queue_update(4, 0, 0);
		queue_update(6, 65535, 0);
		queue_update(6, 100, 5);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			if (p == 0) begin
				set_meter(511, 1, 63, 0);
			end else if (p == 1) begin
				set_meter(0, 1, 1, 65535);
			end else if (p == 2) begin
				set_meter($urandom_range(0, 511), 0, 0, $urandom_range(0, 300));
			end else begin
				set_meter($urandom_range(0, 511), ($urandom_range(0, 3) != 0),
				          ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 63),
				          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				                                      : $urandom_range(0, 300));
			end

			if (p == 5) begin
				// sender pauses halfway until every result is back
				for (int i = 0; i < PHASE_ITEMS / 2; i++) begin
					pending_items.push_back(random_update());
				end
				wait_drained();
				for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++) begin
					pending_items.push_back(random_update());
				end
			end else begin
				for (int i = 0; i < PHASE_ITEMS; i++) begin
					pending_items.push_back(random_update());
				end
				// receiver holds off while the sender keeps offering: input backs up
				if (p == 3) begin
					holdoff_request = LONG_HOLDOFF;
				end
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/lbm_pkg.sv
src/lbm_ram.sv
src/lbm_ctrl.sv
src/lbm_dp.sv
src/led_bar_meter_ballistics.sv
dv/led_bar_meter_ballistics_tb.sv
